// ----- rtl/wol_pkg.sv -----
// Shared types, constants and control codes of the wavetable oscillator.
package wol_pkg;

    // Default sizes, used as the top-level parameter defaults.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths.
    localparam int PHASE_W    = 32;
    localparam int FREQ_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 40;
    localparam int STEP_LO_W  = 32;
    localparam int FRAC_W     = 16;
    localparam int ROUND_SH   = 28;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // Reset value of the per-Hz phase step.
    localparam logic [STEP_W-1:0] STEP_RESET = 40'd5864062015;

    // Input commands; the unused code is ignored.
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_SYNC   = 2'd1,
        CMD_WRITE  = 2'd2
    } cmd_t;

    // Configuration register index, taken from the upper address bit.
    typedef enum logic {
        REG_PHASE_STEP   = 1'b0,
        REG_PHASE_DRIVEN = 1'b1
    } reg_idx_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LERP,
        ST_GAIN,
        ST_OUT
    } state_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_FREQ,
        MUL_DIFF,
        MUL_GAIN
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     rd_en;
        logic     do_sync;
        logic     do_write;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     hi_load;
        logic     inc_load;
        logic     phase_load;
        logic     out_load;
    } dp_cmd_t;

endpackage

// ----- rtl/wol_ctrl.sv -----
// Sequencing state machine of the wavetable oscillator.
module wol_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       command,
    input  logic             out_ready,
    output logic             in_ready,
    output logic             out_valid,
    output wol_pkg::dp_cmd_t dp_cmd
);
    import wol_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    cmd_t   cmd_code;
    logic   out_free;

    assign cmd_code  = cmd_t'(command);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && cmd_code == CMD_SAMPLE)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LERP;
            ST_LERP: state_next = ST_GAIN;
            ST_GAIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb
    begin
        dp_cmd   = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (cmd_code)
                        CMD_SAMPLE: dp_cmd.rd_en    = 1'b1;
                        CMD_SYNC:   dp_cmd.do_sync  = 1'b1;
                        CMD_WRITE:  dp_cmd.do_write = 1'b1;
                        default:    dp_cmd          = '0;
                    endcase
                end
            end
            ST_MUL:
            begin
                dp_cmd.mul_en  = 1'b1;
                dp_cmd.mul_sel = MUL_FREQ;
                dp_cmd.hi_load = 1'b1;
            end
            ST_LERP:
            begin
                dp_cmd.mul_en   = 1'b1;
                dp_cmd.mul_sel  = MUL_DIFF;
                dp_cmd.inc_load = 1'b1;
            end
            ST_GAIN:
            begin
                dp_cmd.mul_en     = 1'b1;
                dp_cmd.mul_sel    = MUL_GAIN;
                dp_cmd.phase_load = 1'b1;
            end
            ST_OUT:
            begin
                dp_cmd.out_load = out_free;
            end
            default: dp_cmd = '0;
        endcase
    end

    // A result becomes valid when loaded and clears when transferred.
    assign out_valid_next = dp_cmd.out_load || (out_valid_reg && !out_ready);

endmodule

// ----- rtl/wol_dpath.sv -----
// Datapath: phase accumulator, wave table, shared multiplier and output stage.
module wol_dpath #(
    parameter int TABLE_DEPTH = wol_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wol_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wol_pkg::dp_cmd_t                       dp_cmd,
    input  logic signed [wol_pkg::FREQ_W-1:0]      freq,
    input  logic signed [wol_pkg::GAIN_W-1:0]      gain,
    input  logic        [wol_pkg::PHASE_W-1:0]     phase_offset,
    input  logic        [wol_pkg::PHASE_W-1:0]     sync_phase,
    input  logic        [$clog2(TABLE_DEPTH)-1:0]  table_index,
    input  logic signed [SAMPLE_BITS-1:0]          table_value,
    input  logic        [wol_pkg::STEP_W-1:0]      phase_step,
    input  logic                                   phase_driven,
    output logic signed [SAMPLE_BITS-1:0]          sample_out
);
    import wol_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PW    = PHASE_W + IDX_W;
    localparam int VW    = SAMPLE_BITS + FRAC_W + 1;
    localparam int AW    = (VW > FREQ_W) ? VW : FREQ_W;
    localparam int BW    = STEP_LO_W + 1;
    localparam int PRW   = AW + BW;
    localparam int RW    = PRW - ROUND_SH;
    localparam int HI_W  = STEP_W - STEP_LO_W;
    localparam logic [IDX_W:0]    DEPTH_V    = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic signed [PRW-1:0] ROUND_BIAS = PRW'(64'sd1 <<< (ROUND_SH - 1));
    localparam logic signed [RW-1:0]  SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0]  SAT_LO = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Wave table storage.
    logic [SAMPLE_BITS-1:0] table_mem [TABLE_DEPTH];

    logic        [PHASE_W-1:0]     phase_acc_reg;
    logic        [PHASE_W-1:0]     phase_acc_next;
    logic signed [FREQ_W-1:0]      freq_reg;
    logic signed [GAIN_W-1:0]      gain_reg;
    logic        [PHASE_W-1:0]     offset_reg;
    logic        [FRAC_W-1:0]      frac_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] b_reg;
    logic        [PHASE_W-1:0]     hi_reg;
    logic        [PHASE_W-1:0]     inc_reg;
    logic signed [PRW-1:0]         prod_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    logic [PW-1:0]         scaled_phase;
    logic [IDX_W-1:0]      idx0;
    logic [IDX_W-1:0]      idx1;
    logic                  write_ok;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [VW-1:0]  interp;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PRW-1:0] mul_p;
    logic [PHASE_W-1:0]    hi_prod;
    logic signed [PRW-1:0] rounded;
    logic signed [RW-1:0]  shifted;

    // Table position: the integer part picks the entry, the fraction weights it.
    assign scaled_phase = PW'(phase_acc_reg) * PW'(TABLE_DEPTH);
    assign idx0 = scaled_phase[PW-1:PHASE_W];
    assign idx1 = (idx0 == LAST_IDX) ? '0 : idx0 + 1'b1;
    assign write_ok = {1'b0, table_index} < DEPTH_V;

    // Table write and registered dual read.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.do_write && write_ok)
        begin
            table_mem[table_index] <= table_value;
        end
        if (dp_cmd.rd_en)
        begin
            a_reg <= table_mem[idx0];
            b_reg <= table_mem[idx1];
        end
    end

    // Item fields held for the length of a sample.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_en)
        begin
            freq_reg   <= freq;
            gain_reg   <= gain;
            offset_reg <= phase_offset;
            frac_reg   <= scaled_phase[PHASE_W-1:PHASE_W-FRAC_W];
        end
    end

    // Interpolated value: a * 2^16 plus (b - a) * f from the previous product.
    assign diff   = (SAMPLE_BITS + 1)'(b_reg) - (SAMPLE_BITS + 1)'(a_reg);
    assign interp = (VW'(a_reg) <<< FRAC_W) + VW'(prod_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (dp_cmd.mul_sel)
            MUL_FREQ:
            begin
                mul_a = AW'(freq_reg);
                mul_b = $signed({1'b0, phase_step[STEP_LO_W-1:0]});
            end
            MUL_DIFF:
            begin
                mul_a = AW'(diff);
                mul_b = $signed({{(BW - FRAC_W){1'b0}}, frac_reg});
            end
            MUL_GAIN:
            begin
                mul_a = AW'(interp);
                mul_b = BW'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Upper step bits only reach the low word of the increment.
    assign hi_prod = freq_reg * PHASE_W'(phase_step[STEP_LO_W +: HI_W]);

    // Product, partial-increment and increment registers.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (dp_cmd.hi_load)
        begin
            hi_reg <= hi_prod;
        end
        if (dp_cmd.inc_load)
        begin
            inc_reg <= prod_reg[2*PHASE_W-1:PHASE_W] + hi_reg;
        end
    end

    // Phase accumulator: sync sets it, a sample advances it modulo one cycle (from zero in phase-driven mode).
    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        if (dp_cmd.do_sync)
        begin
            phase_acc_next = sync_phase;
        end
        else if (dp_cmd.phase_load)
        begin
            phase_acc_next = (phase_driven ? '0 : phase_acc_reg) + inc_reg + offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // Round half up to 2^-28 and saturate to the sample range.
    assign rounded = prod_reg + ROUND_BIAS;
    assign shifted = rounded[PRW-1:ROUND_SH];

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sample_next = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sample_next = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sample_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

// ----- rtl/wavetable_oscillator_lerp.sv -----
// Top level of the wavetable oscillator: configuration registers and block wiring.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid / in_ready     command, freq, gain, phase_offset,
//                                                sync_phase, table_index, table_value
//   output    out        out_valid / out_ready   sample_out
//   config    in         psel / penable / pready paddr, pwrite, pwdata, prdata
//
// A sync or table write transfer completes in the cycle it is accepted.
// A sample passes three steps through the shared multiplier and one rounding step
// before it reaches the output register. No new item is accepted until then; the next
// item can be accepted in the cycle after that load, even while that result still
// waits for out_ready, and a second result waits in its last step.
// Reset clears the phase and loads the configuration defaults; the table holds
// no defined values until written.
module wavetable_oscillator_lerp #(
    parameter int TABLE_DEPTH = wol_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wol_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             command,
    input  logic signed [wol_pkg::FREQ_W-1:0]      freq,
    input  logic signed [wol_pkg::GAIN_W-1:0]      gain,
    input  logic signed [wol_pkg::PHASE_W-1:0]     phase_offset,
    input  logic        [wol_pkg::PHASE_W-1:0]     sync_phase,
    input  logic        [$clog2(TABLE_DEPTH)-1:0]  table_index,
    input  logic signed [SAMPLE_BITS-1:0]          table_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          sample_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [wol_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [wol_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [wol_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import wol_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              driven_reg;
    logic              driven_next;
    logic              cfg_write;
    reg_idx_t          reg_idx;
    dp_cmd_t           dp_cmd;

    // Configuration port: registers sit at byte addresses 0 and 8.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1]);

    always_comb
    begin
        step_next   = step_reg;
        driven_next = driven_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_PHASE_STEP:   step_next   = pwdata[STEP_W-1:0];
                REG_PHASE_DRIVEN: driven_next = pwdata[0];
                default:          step_next   = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            driven_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            driven_reg <= driven_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_PHASE_STEP:   prdata = APB_DATA_W'(step_reg);
            REG_PHASE_DRIVEN: prdata = APB_DATA_W'(driven_reg);
            default:          prdata = '0;
        endcase
    end

    // Controller.
    wol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .dp_cmd    (dp_cmd)
    );

    // Datapath.
    wol_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .freq         (freq),
        .gain         (gain),
        .phase_offset (phase_offset),
        .sync_phase   (sync_phase),
        .table_index  (table_index),
        .table_value  (table_value),
        .phase_step   (step_reg),
        .phase_driven (driven_reg),
        .sample_out   (sample_out)
    );

    // Only one kind of accepted command acts in a cycle.
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.rd_en, dp_cmd.do_sync, dp_cmd.do_write}))
        else $error("more than one command action in a cycle");

    // A result is never loaded over one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // After a sample transfer the block is busy and runs the multiplier.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == CMD_SAMPLE) |=>
            (!in_ready && dp_cmd.mul_en && dp_cmd.hi_load))
        else $error("sample sequence did not start");

    // A sample only advances the phase while the block is busy with it.
    a_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.phase_load |-> !in_ready)
        else $error("phase advanced while idle");

endmodule

// ----- sim/wol_checker.sv -----
// Checker for the wavetable oscillator: predicts every sample and compares the outputs.
module wol_checker #(
    parameter int TABLE_DEPTH = wol_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wol_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic signed [wol_pkg::FREQ_W-1:0]     freq,
    input  logic signed [wol_pkg::GAIN_W-1:0]     gain,
    input  logic signed [wol_pkg::PHASE_W-1:0]    phase_offset,
    input  logic        [wol_pkg::PHASE_W-1:0]    sync_phase,
    input  logic        [$clog2(TABLE_DEPTH)-1:0] table_index,
    input  logic signed [SAMPLE_BITS-1:0]         table_value,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wol_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [wol_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic [wol_pkg::APB_DATA_W-1:0]        prdata,
    input  logic                                  pready,
    output int                                    outstanding,
    output int                                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import wol_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // Shadow copy of the oscillator state and its configuration.
    logic [PHASE_W-1:0]            osc_phase;
    logic [STEP_W-1:0]             step_per_hz;
    logic                          driven_mode;
    logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];

    // Samples predicted but not yet seen on the output channel, oldest first.
    logic signed [SAMPLE_BITS-1:0] sample_q [$];

    // Interpolate the two neighboring entries at a phase, apply gain, round and clamp.
    function automatic logic signed [SAMPLE_BITS-1:0] render_sample(
        input logic [PHASE_W-1:0] ph,
        input logic signed [GAIN_W-1:0] g
    );
        logic [IDX_W-1:0]  lo_idx;
        logic [IDX_W-1:0]  hi_idx;
        logic [FRAC_W-1:0] frac;
        longint            mix;
        longint            scaled;
        longint            rounded;
        lo_idx  = ph[PHASE_W-1 -: IDX_W];
        hi_idx  = lo_idx + 1'b1;
        frac    = ph[PHASE_W-1-IDX_W -: FRAC_W];
        mix     = longint'(wave_mem[lo_idx]) * ((longint'(1) <<< FRAC_W) - longint'(frac))
                + longint'(wave_mem[hi_idx]) * longint'(frac);
        scaled  = mix * longint'(g);
        rounded = (scaled + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (rounded > SAT_HI)
            rounded = SAT_HI;
        if (rounded < SAT_LO)
            rounded = SAT_LO;
        return rounded[SAMPLE_BITS-1:0];
    endfunction

    // Next phase: old phase (0 if driven) + signed frequency * per-Hz step + offset.
    function automatic logic [PHASE_W-1:0] next_phase(
        input logic signed [FREQ_W-1:0]  f,
        input logic signed [PHASE_W-1:0] off
    );
        logic [63:0]        freq_ext;
        logic [63:0]        product;
        logic [PHASE_W-1:0] base;
        freq_ext = {{(64-FREQ_W){f[FREQ_W-1]}}, f};
        product  = freq_ext * {{(64-STEP_W){1'b0}}, step_per_hz};
        base     = driven_mode ? '0 : osc_phase;
        return base + product[63:32] + off;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [SAMPLE_BITS-1:0] want;
        if (!rst_n)
        begin
            osc_phase   <= '0;
            step_per_hz <= STEP_RESET;
            driven_mode <= 1'b0;
            sample_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            // Register writes update the shadow; reads are compared against it.
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[APB_ADDR_W-1]))
                        REG_PHASE_STEP:   step_per_hz <= pwdata[STEP_W-1:0];
                        REG_PHASE_DRIVEN: driven_mode <= pwdata[0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (reg_idx_t'(paddr[APB_ADDR_W-1]))
                        REG_PHASE_STEP:
                            if (prdata[STEP_W-1:0] !== step_per_hz)
                                report_mismatch($sformatf("phase step read %h, expected %h",
                                    prdata[STEP_W-1:0], step_per_hz));
                        REG_PHASE_DRIVEN:
                            if (prdata[0] !== driven_mode)
                                report_mismatch($sformatf("phase-driven read %b, expected %b",
                                    prdata[0], driven_mode));
                        default: ;
                    endcase
                end
            end

            // Output transfer: compare with the oldest predicted sample.
            if (out_valid && out_ready)
            begin
                if (sample_q.size() == 0)
                begin
                    report_mismatch($sformatf("sample %0d with none expected", sample_out));
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (sample_out !== want)
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                            sample_out, want));
                end
            end

            // Input transfer: apply the command to the shadow state.
            if (in_valid && in_ready)
            begin
                case (cmd_t'(command))
                    CMD_SAMPLE:
                    begin
                        sample_q.push_back(render_sample(osc_phase, gain));
                        osc_phase <= next_phase(freq, phase_offset);
                    end
                    CMD_SYNC:  osc_phase <= sync_phase;
                    CMD_WRITE: wave_mem[table_index] <= table_value;
                    default: ;
                endcase
            end

            outstanding <= sample_q.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the wavetable oscillator: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wol_pkg::*;

    localparam int TBL_DEPTH     = DEF_TABLE_DEPTH;
    localparam int SMP_BITS      = DEF_SAMPLE_BITS;
    localparam int IDX_W         = $clog2(TBL_DEPTH);
    localparam int RANDOM_ITEMS  = 800;
    localparam int NUM_PHASES    = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 500;

    // The spare command code, which the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   command;
    logic signed [FREQ_W-1:0]     freq;
    logic signed [GAIN_W-1:0]     gain;
    logic signed [PHASE_W-1:0]    phase_offset;
    logic        [PHASE_W-1:0]    sync_phase;
    logic        [IDX_W-1:0]      table_index;
    logic signed [SMP_BITS-1:0]   table_value;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [SMP_BITS-1:0]   sample_out;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;

    int   outstanding;
    int   fail_count;
    int   idle_cycles;
    logic fast_mode = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wavetable_oscillator_lerp #(
        .TABLE_DEPTH(TBL_DEPTH),
        .SAMPLE_BITS(SMP_BITS)
    ) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .freq(freq), .gain(gain), .phase_offset(phase_offset),
        .sync_phase(sync_phase), .table_index(table_index), .table_value(table_value),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wol_checker #(
        .TABLE_DEPTH(TBL_DEPTH),
        .SAMPLE_BITS(SMP_BITS)
    ) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .freq(freq), .gain(gain), .phase_offset(phase_offset),
        .sync_phase(sync_phase), .table_index(table_index), .table_value(table_value),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .outstanding(outstanding), .fail_count(fail_count)
    );

    // Watchdog: the run ends if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: after each transfer, hold off for a random number of cycles.
    initial
    begin : sink
        int hold;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                hold = fast_mode ? 0 : $urandom_range(0, 15);
                if (hold != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // One input transfer after a random gap; returns at the edge that accepts it.
    task automatic send_item(
        input logic [1:0]                 cmd,
        input logic signed [FREQ_W-1:0]   f,
        input logic signed [GAIN_W-1:0]   g,
        input logic signed [PHASE_W-1:0]  off,
        input logic [PHASE_W-1:0]         sp,
        input logic [IDX_W-1:0]           idx,
        input logic signed [SMP_BITS-1:0] val
    );
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        freq         <= f;
        gain         <= g;
        phase_offset <= off;
        sync_phase   <= sp;
        table_index  <= idx;
        table_value  <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    // Unused fields of each command carry random values.
    task automatic send_sample(
        input logic signed [FREQ_W-1:0]  f,
        input logic signed [GAIN_W-1:0]  g,
        input logic signed [PHASE_W-1:0] off
    );
        send_item(CMD_SAMPLE, f, g, off, $urandom, IDX_W'($urandom), SMP_BITS'($urandom));
    endtask

    task automatic send_sync(input logic [PHASE_W-1:0] sp);
        send_item(CMD_SYNC, $urandom, GAIN_W'($urandom), $urandom, sp,
                  IDX_W'($urandom), SMP_BITS'($urandom));
    endtask

    task automatic send_write(
        input logic [IDX_W-1:0]           idx,
        input logic signed [SMP_BITS-1:0] val
    );
        send_item(CMD_WRITE, $urandom, GAIN_W'($urandom), $urandom, $urandom, idx, val);
    endtask

    task automatic send_unused();
        send_item(CMD_UNUSED, $urandom, GAIN_W'($urandom), $urandom, $urandom,
                  IDX_W'($urandom), SMP_BITS'($urandom));
    endtask

    // Register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input reg_idx_t idx, input logic wr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, {(APB_ADDR_W-1){1'b0}}};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending and wait until every predicted sample has come out.
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A random command: mostly samples, with syncs, table rewrites and the spare code.
    task automatic random_item();
        int                        pick;
        logic signed [FREQ_W-1:0]  f;
        logic signed [GAIN_W-1:0]  g;
        logic signed [PHASE_W-1:0] off;
        pick = $urandom_range(0, 99);
        f    = $urandom_range(0, 1) ? $urandom
                                    : $signed($urandom_range(0, 40000 << 16)) - (20000 << 16);
        g    = GAIN_W'($urandom_range(0, 2) == 0 ? $urandom
                                                 : $signed($urandom_range(0, 8192)) - 4096);
        off  = $urandom_range(0, 1) ? 0 : $urandom;
        if (pick < 70)
            send_sample(f, g, off);
        else if (pick < 80)
            send_sync($urandom);
        else if (pick < 95)
            send_write(IDX_W'($urandom), SMP_BITS'($urandom));
        else
            send_unused();
    endtask

    initial
    begin : stimulus
        logic [STEP_W-1:0] step_plan [NUM_PHASES];
        logic              driven_plan [NUM_PHASES];
        logic signed [SMP_BITS-1:0] fill;

        in_valid     = 1'b0;
        command      = CMD_SAMPLE;
        freq         = '0;
        gain         = '0;
        phase_offset = '0;
        sync_phase   = '0;
        table_index  = '0;
        table_value  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        step_plan[0] = STEP_RESET;                   driven_plan[0] = 1'b0;
        step_plan[1] = '0;                           driven_plan[1] = 1'b1;
        step_plan[2] = '1;                           driven_plan[2] = 1'b0;
        step_plan[3] = STEP_W'({$urandom, $urandom}); driven_plan[3] = 1'b1;
        step_plan[4] = STEP_W'({$urandom, $urandom}); driven_plan[4] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of both registers.
        apb_access(REG_PHASE_STEP, 1'b0, '0);
        apb_access(REG_PHASE_DRIVEN, 1'b0, '0);

        // Load every table entry before any sample reads one; full-scale values at the ends.
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (i % 64 == 0)
                fast_mode = ($urandom_range(0, 3) == 0);
            if (i < 2)
                fill = {1'b0, {(SMP_BITS-1){1'b1}}};
            else if (i < 4 || i == TBL_DEPTH - 1)
                fill = {1'b1, {(SMP_BITS-1){1'b0}}};
            else
                fill = SMP_BITS'($urandom);
            send_write(IDX_W'(i), fill);
        end

        // Directed part: gain extremes and saturation, wrap of the table index and phase.
        fast_mode = 1'b0;
        send_sync('0);
        send_sample(0, 16'sd4096, 0);
        send_sample(0, 16'sh7FFF, 0);
        send_sample(0, 16'sh8000, 0);
        send_sample(0, 16'sd0, 0);
        send_sync(32'h0080_0000);
        send_sample(0, 16'sh8000, 0);
        send_sync(32'hFFFF_FFFF);
        send_sample(32'sh7FFF_FFFF, 16'sd4096, 32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000, 16'sh7FFF, 32'sh8000_0000);
        send_sample(-32'sd65536, -16'sd4096, 0);
        send_unused();
        send_unused();
        send_sample(32'sd65536, 16'sd4096, 32'sh0000_0040);
        send_write('1, 16'sh7FFF);
        send_write('0, 16'sh8000);
        send_sync(32'hFFC0_0000);
        send_sample(0, 16'sd4096, 32'sh0000_0040);
        send_sample(32'sd65536, 16'sh7FFF, 0);

        // Random part, one register setting per stretch; the block drains between them.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            apb_access(REG_PHASE_STEP, 1'b1,
                       {(APB_DATA_W-STEP_W)'($urandom), step_plan[ph]});
            apb_access(REG_PHASE_DRIVEN, 1'b1,
                       {$urandom, (APB_DATA_W-33)'($urandom), driven_plan[ph]});
            apb_access(REG_PHASE_STEP, 1'b0, '0);
            apb_access(REG_PHASE_DRIVEN, 1'b0, '0);
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
            begin
                if (n % 32 == 0)
                    fast_mode = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        fast_mode = 1'b0;
        settle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
